/* rtl/core/wpi_pkg.sv */
// Shared types, constants and codes of the wind profile interpolator.
`default_nettype none

package wpi_pkg;

  // Elaboration defaults for the top-level parameters
  localparam int unsigned MAX_POINTS_DEF = 16;
  localparam int unsigned RATIO_BITS_DEF = 10;

  // Fixed field widths
  localparam int unsigned OPCODE_W = 1;
  localparam int unsigned INDEX_W  = 4;
  localparam int unsigned HEIGHT_W = 16;
  localparam int unsigned SPEED_W  = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 5;

  // Configuration port
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_POINTS_IN_USE = 1'b0;
  localparam logic [CFG_W-1:0] POINTS_RESET = CFG_W'(2);

  // Shared unit: 32x16 multiply-accumulate, restoring divide step
  localparam int unsigned MAC_A_W = 32;
  localparam int unsigned MAC_B_W = 16;
  localparam int unsigned MAC_R_W = MAC_A_W + MAC_B_W;
  localparam int unsigned DVD_W   = 32;
  localparam int unsigned DIV_STEPS = DVD_W;

  // Power law 0.15 = 3/20: compare p^20 against r^3 scaled
  localparam int unsigned POW_EXP   = 20;
  localparam int unsigned POW_ROOT  = 3;
  localparam int unsigned POW_W     = POW_EXP * SPEED_W;
  localparam int unsigned LIMB_W    = 32;
  localparam int unsigned POW_LIMBS = POW_W / LIMB_W;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned ROUND_HALF = 32768;

  // Opcodes and status codes
  localparam logic [OPCODE_W-1:0] OP_LOAD = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_EVAL = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_VALID    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_VALUE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_LOAD_ACK = 2'd2;

  typedef struct packed {
    logic [OPCODE_W-1:0]        opcode;
    logic [INDEX_W-1:0]         point_index;
    logic [HEIGHT_W-1:0]        point_height;
    logic [SPEED_W-1:0]         point_speed;
    logic signed [HEIGHT_W-1:0] query_height;
  } wpi_in_t;

  typedef struct packed {
    logic [SPEED_W-1:0]  wind_speed;
    logic [STATUS_W-1:0] status;
  } wpi_out_t;

  typedef enum logic {
    ALU_MAC,
    ALU_DIV
  } wpi_alu_op_e;

  typedef struct packed {
    wpi_alu_op_e        op;
    logic [MAC_A_W-1:0] a;
    logic [MAC_B_W-1:0] b;
    logic [MAC_A_W-1:0] c;
  } wpi_alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } wpi_ctrl_sts_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_SCAN,
    ST_MUL,
    ST_IDIV,
    ST_ISUM,
    ST_RDIV,
    ST_RSQ,
    ST_RCUBE,
    ST_SRCH,
    ST_POW,
    ST_CMP,
    ST_SCALE,
    ST_DONE
  } wpi_state_e;

endpackage

`default_nettype wire

/* rtl/core/wpi_table.sv */
// Breakpoint store: height and speed memories with registered read.
`default_nettype none

module wpi_table #(
  parameter int unsigned MAX_POINTS = wpi_pkg::MAX_POINTS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] wr_addr_i,
  input  wire logic [wpi_pkg::HEIGHT_W-1:0]  wr_height_i,
  input  wire logic [wpi_pkg::SPEED_W-1:0]   wr_speed_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] rd_addr_i,
  output logic      [wpi_pkg::HEIGHT_W-1:0]  rd_height_o,
  output logic      [wpi_pkg::SPEED_W-1:0]   rd_speed_o
);
  import wpi_pkg::*;

  logic [HEIGHT_W-1:0] height_mem [MAX_POINTS];
  logic [SPEED_W-1:0]  speed_mem  [MAX_POINTS];
  logic [HEIGHT_W-1:0] rd_height_q;
  logic [SPEED_W-1:0]  rd_speed_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      height_mem[wr_addr_i] <= wr_height_i;
      speed_mem[wr_addr_i]  <= wr_speed_i;
    end
    rd_height_q <= height_mem[rd_addr_i];
    rd_speed_q  <= speed_mem[rd_addr_i];
  end

  assign rd_height_o = rd_height_q;
  assign rd_speed_o  = rd_speed_q;

endmodule

`default_nettype wire

/* rtl/core/wpi_alu.sv */
// Shared arithmetic unit: multiply-accumulate and one restoring divide step.
`default_nettype none

module wpi_alu (
  input  wire wpi_pkg::wpi_alu_req_t        req_i,
  output logic [wpi_pkg::MAC_R_W-1:0]       res_o
);
  import wpi_pkg::*;

  logic [MAC_R_W-1:0] mac;
  logic [SPEED_W:0]   trial_rem;
  logic [SPEED_W:0]   trial;

  always_comb begin
    mac       = (MAC_R_W'(req_i.a) * MAC_R_W'(req_i.b)) + MAC_R_W'(req_i.c);
    // a holds {remainder, next dividend bit}; b holds the divisor
    trial_rem = req_i.a[SPEED_W:0];
    trial     = trial_rem - {1'b0, req_i.b};
    case (req_i.op)
      ALU_MAC: res_o = mac;
      ALU_DIV: begin
        if (trial_rem >= {1'b0, req_i.b}) begin
          res_o = MAC_R_W'({1'b1, trial[SPEED_W-1:0]});
        end else begin
          res_o = MAC_R_W'({1'b0, trial_rem[SPEED_W-1:0]});
        end
      end
      default: res_o = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/wpi_ctrl.sv */
// Sequencer: table search, interpolation and power-law evaluation on the shared unit.
`default_nettype none

module wpi_ctrl #(
  parameter int unsigned MAX_POINTS = wpi_pkg::MAX_POINTS_DEF,
  parameter int unsigned RATIO_BITS = wpi_pkg::RATIO_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire wpi_pkg::wpi_in_t              req_i,
  input  wire logic [$clog2(MAX_POINTS)-1:0] last_idx_i,
  input  wire logic                          res_take_i,
  output wpi_pkg::wpi_ctrl_sts_t             sts_o,
  output wpi_pkg::wpi_out_t                  res_o,
  output logic      [$clog2(MAX_POINTS)-1:0] rd_addr_o,
  input  wire logic [wpi_pkg::HEIGHT_W-1:0]  rd_height_i,
  input  wire logic [wpi_pkg::SPEED_W-1:0]   rd_speed_i,
  output wpi_pkg::wpi_alu_req_t              alu_req_o,
  input  wire logic [wpi_pkg::MAC_R_W-1:0]   alu_res_i
);
  import wpi_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_POINTS);
  localparam int unsigned ZW     = HEIGHT_W - 1;
  localparam int unsigned R3W    = POW_ROOT * RATIO_BITS;
  localparam int unsigned ShiftW = POW_W - R3W;

  wpi_state_e          state_q, state_d;
  logic [ZW-1:0]       z_q, z_d;
  logic [IdxW-1:0]     idx_q, idx_d;
  logic [HEIGHT_W-1:0] prev_h_q, prev_h_d;
  logic [SPEED_W-1:0]  prev_v_q, prev_v_d;
  logic [HEIGHT_W-1:0] den_q, den_d;
  logic [MAC_A_W-1:0]  opa_q, opa_d;
  logic [MAC_B_W-1:0]  opb_q, opb_d;
  logic [SPEED_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]    dvd_q, dvd_d;
  logic                neg_q, neg_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [STEP_W-1:0]   pass_q, pass_d;
  logic [R3W-1:0]      r3_q, r3_d;
  logic [SPEED_W-1:0]  lo_q, lo_d;
  logic [SPEED_W-1:0]  hi_q, hi_d;
  logic [SPEED_W-1:0]  mid_q, mid_d;
  logic [POW_W-1:0]    pw_q, pw_d;
  logic [MAC_B_W-1:0]  carry_q, carry_d;
  wpi_out_t            res_q, res_d;

  logic [HEIGHT_W-1:0] z_ext;
  logic                below_first;
  logic                at_top;
  logic                seg_found;
  logic                div_last;
  logic                limb_last;
  logic                pass_last;
  logic                search_open;
  logic [SPEED_W:0]    mid_sum;
  logic [R3W-1:0]      pow_hi;
  logic                pow_ok;
  logic [33:0]         isum;
  logic [RATIO_BITS-1:0] ratio;

  // Shared conditions
  always_comb begin
    z_ext       = {1'b0, z_q};
    below_first = z_ext < rd_height_i;
    at_top      = z_ext >= rd_height_i;
    seg_found   = (z_ext < rd_height_i) || (idx_q == last_idx_i);
    div_last    = step_q == STEP_W'(DIV_STEPS - 1);
    limb_last   = step_q == STEP_W'(POW_LIMBS - 1);
    pass_last   = pass_q == STEP_W'(POW_EXP - 1);
    search_open = lo_q < hi_q;
    mid_sum     = {1'b0, lo_q} + {1'b0, hi_q} + (SPEED_W + 1)'(1);
    pow_hi      = pw_q[POW_W-1:ShiftW];
    pow_ok      = (pow_hi < r3_q) || ((pow_hi == r3_q) && !(|pw_q[ShiftW-1:0]));
    isum        = neg_q ? (34'(prev_v_q) - 34'(dvd_q)) : (34'(prev_v_q) + 34'(dvd_q));
    ratio       = dvd_q[RATIO_BITS-1:0];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_i.opcode == OP_LOAD || req_i.query_height[HEIGHT_W-1]) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_FIRST;
          end
        end
      end
      ST_FIRST: state_d = below_first ? ST_RDIV : ST_LAST;
      ST_LAST:  state_d = at_top ? ST_DONE : ST_SCAN;
      ST_SCAN:  state_d = seg_found ? ST_MUL : ST_SCAN;
      ST_MUL:   state_d = ST_IDIV;
      ST_IDIV:  state_d = div_last ? ST_ISUM : ST_IDIV;
      ST_ISUM:  state_d = ST_DONE;
      ST_RDIV:  state_d = div_last ? ST_RSQ : ST_RDIV;
      ST_RSQ:   state_d = ST_RCUBE;
      ST_RCUBE: state_d = ST_SRCH;
      ST_SRCH:  state_d = search_open ? ST_POW : ST_SCALE;
      ST_POW:   state_d = (limb_last && pass_last) ? ST_CMP : ST_POW;
      ST_CMP:   state_d = ST_SRCH;
      ST_SCALE: state_d = ST_DONE;
      ST_DONE:  state_d = res_take_i ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    z_d      = z_q;
    idx_d    = idx_q;
    prev_h_d = prev_h_q;
    prev_v_d = prev_v_q;
    den_d    = den_q;
    opa_d    = opa_q;
    opb_d    = opb_q;
    rem_d    = rem_q;
    dvd_d    = dvd_q;
    neg_d    = neg_q;
    step_d   = step_q;
    pass_d   = pass_q;
    r3_d     = r3_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    pw_d     = pw_q;
    carry_d  = carry_q;
    res_d    = res_q;

    alu_req_o    = '0;
    alu_req_o.op = ALU_MAC;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          z_d   = req_i.query_height[ZW-1:0];
          idx_d = '0;
          res_d.wind_speed = '0;
          if (req_i.opcode == OP_LOAD) begin
            res_d.status = STATUS_LOAD_ACK;
          end else begin
            res_d.status = STATUS_NO_VALUE;
          end
        end
      end
      ST_FIRST: begin
        prev_h_d = rd_height_i;
        prev_v_d = rd_speed_i;
        if (below_first) begin
          // ratio z/h0 in Q0.RATIO_BITS
          dvd_d  = DVD_W'({z_q, {RATIO_BITS{1'b0}}});
          den_d  = rd_height_i;
          rem_d  = '0;
          step_d = '0;
        end else begin
          idx_d = last_idx_i;
        end
      end
      ST_LAST: begin
        if (at_top) begin
          res_d.wind_speed = rd_speed_i;
          res_d.status     = STATUS_VALID;
        end else begin
          idx_d = IdxW'(1);
        end
      end
      ST_SCAN: begin
        if (seg_found) begin
          den_d = rd_height_i - prev_h_q;
          opa_d = MAC_A_W'(z_ext - prev_h_q);
          neg_d = rd_speed_i < prev_v_q;
          opb_d = (rd_speed_i < prev_v_q) ? (prev_v_q - rd_speed_i)
                                          : (rd_speed_i - prev_v_q);
        end else begin
          prev_h_d = rd_height_i;
          prev_v_d = rd_speed_i;
          idx_d    = idx_q + IdxW'(1);
        end
      end
      ST_MUL: begin
        // |num| + den/2, the rounding bias folded into the accumulate
        alu_req_o.a = opa_q;
        alu_req_o.b = opb_q;
        alu_req_o.c = MAC_A_W'(den_q >> 1);
        dvd_d  = alu_res_i[DVD_W-1:0];
        rem_d  = '0;
        step_d = '0;
      end
      ST_IDIV, ST_RDIV: begin
        alu_req_o.op = ALU_DIV;
        alu_req_o.a  = MAC_A_W'({rem_q, dvd_q[DVD_W-1]});
        alu_req_o.b  = den_q;
        rem_d  = alu_res_i[SPEED_W-1:0];
        dvd_d  = {dvd_q[DVD_W-2:0], alu_res_i[SPEED_W]};
        step_d = step_q + STEP_W'(1);
      end
      ST_ISUM: begin
        res_d.status = STATUS_VALID;
        if (isum[33]) begin
          res_d.wind_speed = '0;
        end else if (|isum[32:SPEED_W]) begin
          res_d.wind_speed = '1;
        end else begin
          res_d.wind_speed = isum[SPEED_W-1:0];
        end
      end
      ST_RSQ: begin
        alu_req_o.a = MAC_A_W'(ratio);
        alu_req_o.b = MAC_B_W'(ratio);
        opa_d = alu_res_i[MAC_A_W-1:0];
        opb_d = MAC_B_W'(ratio);
      end
      ST_RCUBE: begin
        alu_req_o.a = opa_q;
        alu_req_o.b = opb_q;
        r3_d = alu_res_i[R3W-1:0];
        lo_d = '0;
        hi_d = '1;
      end
      ST_SRCH: begin
        if (search_open) begin
          mid_d   = mid_sum[SPEED_W:1];
          pw_d    = POW_W'(1);
          carry_d = '0;
          step_d  = '0;
          pass_d  = '0;
        end
      end
      ST_POW: begin
        // one limb of pw * mid per cycle, rotating the word through the unit
        alu_req_o.a = pw_q[LIMB_W-1:0];
        alu_req_o.b = mid_q;
        alu_req_o.c = MAC_A_W'(carry_q);
        pw_d    = {alu_res_i[LIMB_W-1:0], pw_q[POW_W-1:LIMB_W]};
        carry_d = alu_res_i[MAC_R_W-1:LIMB_W];
        step_d  = step_q + STEP_W'(1);
        if (limb_last) begin
          carry_d = '0;
          step_d  = '0;
          pass_d  = pass_q + STEP_W'(1);
        end
      end
      ST_CMP: begin
        if (pow_ok) begin
          lo_d = mid_q;
        end else begin
          hi_d = mid_q - SPEED_W'(1);
        end
      end
      ST_SCALE: begin
        alu_req_o.a = MAC_A_W'(prev_v_q);
        alu_req_o.b = lo_q;
        alu_req_o.c = MAC_A_W'(ROUND_HALF);
        res_d.wind_speed = alu_res_i[2*SPEED_W-1:SPEED_W];
        res_d.status     = STATUS_VALID;
      end
      default: ;
    endcase

    rd_addr_o  = idx_d;
    sts_o.busy = state_q != ST_IDLE;
    sts_o.done = state_q == ST_DONE;
    res_o      = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q      <= z_d;
    idx_q    <= idx_d;
    prev_h_q <= prev_h_d;
    prev_v_q <= prev_v_d;
    den_q    <= den_d;
    opa_q    <= opa_d;
    opb_q    <= opb_d;
    rem_q    <= rem_d;
    dvd_q    <= dvd_d;
    neg_q    <= neg_d;
    step_q   <= step_d;
    pass_q   <= pass_d;
    r3_q     <= r3_d;
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    pw_q     <= pw_d;
    carry_q  <= carry_d;
    res_q    <= res_d;
  end

endmodule

`default_nettype wire

/* rtl/core/wind_profile_interpolator.sv */
// Top level of the wind profile interpolator: ports, register, table, unit, sequencer.
//
//   channel   direction  handshake                payload
//   request   in         in_valid_i / in_stall_o  in_data_i  (wpi_in_t)
//   result    out        out_valid_o / out_stall_i out_data_o (wpi_out_t)
//   config    in         psel/penable/pwrite      paddr, pwdata, prdata
//
// One request at a time; in_stall_o stays high while the sequencer works on it.
// Per request: a load or negative height goes straight to the result; a height at
// or above the top clamp reads the first and last points; interpolation in segment i
// scans up to it, multiplies and runs the restoring divide; below the first point the
// power-law search dominates: 16 trials of p^20, each built limb by limb in the MAC.
// Reset clears the sequencer, the output valid flag and points_in_use (to 2); the
// tables hold whatever was last loaded and are undefined until written.
// A stalled result sits in the output register; the next request is taken meanwhile.
`default_nettype none

module wind_profile_interpolator #(
  parameter int unsigned MAX_POINTS = wpi_pkg::MAX_POINTS_DEF,
  parameter int unsigned RATIO_BITS = wpi_pkg::RATIO_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire wpi_pkg::wpi_in_t               in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output wpi_pkg::wpi_out_t                   out_data_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [wpi_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [wpi_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [wpi_pkg::APB_DATA_W-1:0] prdata,
  output logic                                pready
);
  import wpi_pkg::*;

  localparam int unsigned IdxW = $clog2(MAX_POINTS);

  logic [CFG_W-1:0]    points_q, points_d;
  logic                out_valid_q, out_valid_d;
  wpi_out_t            out_data_q, out_data_d;

  logic                in_accept;
  logic                cfg_write;
  logic                res_take;
  logic                wr_en;
  logic [IdxW-1:0]     wr_addr;
  logic [IdxW-1:0]     last_idx;
  logic [IdxW-1:0]     rd_addr;
  logic [HEIGHT_W-1:0] rd_height;
  logic [SPEED_W-1:0]  rd_speed;
  wpi_ctrl_sts_t       sts;
  wpi_out_t            res;
  wpi_alu_req_t        alu_req;
  logic [MAC_R_W-1:0]  alu_res;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = sts.busy;

  // Configuration register; a write with paddr[2] set is dropped
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    points_d = points_q;
    if (cfg_write && paddr[2] == REG_POINTS_IN_USE) begin
      points_d = pwdata[CFG_W-1:0];
    end
    prdata = (paddr[2] == REG_POINTS_IN_USE) ? APB_DATA_W'(points_q) : '0;
  end

  // Clamp the point count to 2..MAX_POINTS and take the top index
  always_comb begin
    if (32'(points_q) < 32'd2) begin
      last_idx = IdxW'(1);
    end else if (32'(points_q) > MAX_POINTS) begin
      last_idx = IdxW'(MAX_POINTS - 1);
    end else begin
      last_idx = IdxW'(32'(points_q) - 32'd1);
    end
  end

  // Load on accept; drop slots beyond the table but still acknowledge them
  assign wr_en   = in_accept && (in_data_i.opcode == OP_LOAD) &&
                   (32'(in_data_i.point_index) < MAX_POINTS);
  assign wr_addr = IdxW'(32'(in_data_i.point_index));

  // Output register: advance a finished result when the slot is free or draining
  always_comb begin
    res_take    = sts.done && (!out_valid_q || !out_stall_i);
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_q    <= POINTS_RESET;
      out_valid_q <= 1'b0;
    end else begin
      points_q    <= points_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  wpi_table #(
    .MAX_POINTS (MAX_POINTS)
  ) u_table (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_height_i (in_data_i.point_height),
    .wr_speed_i  (in_data_i.point_speed),
    .rd_addr_i   (rd_addr),
    .rd_height_o (rd_height),
    .rd_speed_o  (rd_speed)
  );

  wpi_alu u_alu (
    .req_i (alu_req),
    .res_o (alu_res)
  );

  wpi_ctrl #(
    .MAX_POINTS (MAX_POINTS),
    .RATIO_BITS (RATIO_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_accept),
    .req_i       (in_data_i),
    .last_idx_i  (last_idx),
    .res_take_i  (res_take),
    .sts_o       (sts),
    .res_o       (res),
    .rd_addr_o   (rd_addr),
    .rd_height_i (rd_height),
    .rd_speed_i  (rd_speed),
    .alu_req_o   (alu_req),
    .alu_res_i   (alu_res)
  );

endmodule

`default_nettype wire

/* rtl/core/wpi_checker.sv */
// Port-level checks for the wind profile interpolator, bound to the top level.
`default_nettype none

module wpi_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_stall_o,
  input wire logic              out_valid_o,
  input wire logic              out_stall_i,
  input wire wpi_pkg::wpi_out_t out_data_o
);
  import wpi_pkg::*;

  // Hold off further requests once one is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted without raising stall");

  // Hold a stalled result
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Drive speed to zero for load acknowledges and heights below ground
  a_zero_speed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != STATUS_VALID) |-> out_data_o.wind_speed == '0)
    else $error("non-valid status carries a speed");

  // A fresh result only follows a request in progress
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a request in progress");

endmodule

bind wind_profile_interpolator wpi_checker u_wpi_checker (.*);

`default_nettype wire
